// ===== hdl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int DEPTH = 64;
  localparam int PW    = 7;                        // position / length field width
  localparam int DW    = 32;                       // entry width
  localparam int CW    = $clog2(DEPTH + 1);        // count width
  localparam int KW    = (CW > PW) ? CW : PW;      // compare width for indexes

  typedef enum logic [2:0] {
    ACT_INSERT    = 3'd0,
    ACT_APPEND    = 3'd1,
    ACT_DELETE    = 3'd2,
    ACT_DEL_VALUE = 3'd3,
    ACT_OVERWRITE = 3'd4,
    ACT_READ      = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_FULL   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    C_HOLD,
    C_INS,
    C_DEL,
    C_WR,
    C_ROT
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_SWEEP
  } state_t;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    cell_op_t        op;
    logic [KW-1:0]   pos;
    logic [DW-1:0]   data;
    logic            wen;
  } cell_ctl_t;

endpackage

// ===== hdl/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine
// Packed list of up to DEPTH 32-bit entries held in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall) carries action, position, value.
//   Response channel (rsp_valid / rsp_stall) carries status, read_value and
//   length, one response beat per request beat, in order.
//   For insert, append, delete at position, overwrite and read the response
//   beat appears the cycle after the request beat, and a new request is
//   taken every cycle while the response side keeps up.
//   Delete value rotates the whole chain once through cell 0, one entry per
//   cycle, with req_stall high for the whole sweep; its response beat follows
//   the last step of the sweep, or the cycle after the request beat on an
//   empty list.
//   While a response waits under rsp_stall, req_stall is high and the held
//   response does not change.
//   Reset zeroes the entry count and drops any pending response; entries and
//   the length output keep their values; only entries below the count show.
// ----------------------------------------------------------------------------
module positional_list_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [2:0]                      action,
  input  logic [ple_pkg::PW-1:0]          position,
  input  logic signed [ple_pkg::DW-1:0]   value,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [1:0]                      status,
  output logic signed [ple_pkg::DW-1:0]   read_value,
  output logic [ple_pkg::PW-1:0]          length
);

  localparam int DEPTH = ple_pkg::DEPTH;
  localparam int CW    = ple_pkg::CW;
  localparam int KW    = ple_pkg::KW;
  localparam int DW    = ple_pkg::DW;

  ple_pkg::state_t     state, state_next;
  ple_pkg::cell_ctl_t  ctl;

  logic [CW-1:0]  count, count_next;
  logic [CW-1:0]  rem, rem_next;
  logic [CW-1:0]  kept, kept_next;
  logic [DW-1:0]  mval, mval_next;

  logic [DW-1:0]  cell_val [DEPTH];
  logic [DW-1:0]  cell_rd  [DEPTH];
  logic [DW-1:0]  rd_or;

  logic           accept;
  logic           load;
  logic           keep;
  logic [1:0]     stat_n;
  logic [DW-1:0]  rv_n;
  logic [KW-1:0]  pos_k;
  logic [KW-1:0]  count_k;

  assign pos_k   = KW'(position);
  assign count_k = KW'(count);

  assign req_stall = (state != ple_pkg::S_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign keep      = (cell_val[0] != mval);

  // cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DW-1:0] lft, rgt;
    if (g == 0) begin : g_head
      assign lft = ctl.data;
    end else begin : g_mid_l
      assign lft = cell_val[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign rgt = cell_val[g];
    end else begin : g_mid_r
      assign rgt = cell_val[g+1];
    end
    ple_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .idx   (KW'(g)),
      .left  (lft),
      .right (rgt),
      .val   (cell_val[g]),
      .rd    (cell_rd[g])
    );
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    rem_next   = rem;
    kept_next  = kept;
    mval_next  = mval;
    load       = 1'b0;
    stat_n     = ple_pkg::STAT_OK;
    rv_n       = '0;
    ctl.op     = ple_pkg::C_HOLD;
    ctl.pos    = pos_k;
    ctl.data   = value;
    ctl.wen    = 1'b0;

    case (state)
      ple_pkg::S_IDLE: begin
        if (accept) begin
          load = 1'b1;
          case (ple_pkg::action_t'(action))
            ple_pkg::ACT_INSERT: begin
              if (pos_k > count_k) begin
                stat_n = ple_pkg::STAT_BADPOS;
              end else if (count == CW'(DEPTH)) begin
                stat_n = ple_pkg::STAT_FULL;
              end else begin
                ctl.op     = ple_pkg::C_INS;
                count_next = count + CW'(1);
              end
            end
            ple_pkg::ACT_APPEND: begin
              if (count == CW'(DEPTH)) begin
                stat_n = ple_pkg::STAT_FULL;
              end else begin
                ctl.op     = ple_pkg::C_INS;
                ctl.pos    = count_k;
                count_next = count + CW'(1);
              end
            end
            ple_pkg::ACT_DELETE: begin
              if (pos_k >= count_k) begin
                stat_n = ple_pkg::STAT_BADPOS;
              end else begin
                ctl.op     = ple_pkg::C_DEL;
                count_next = count - CW'(1);
              end
            end
            ple_pkg::ACT_DEL_VALUE: begin
              if (count != '0) begin
                load       = 1'b0;
                state_next = ple_pkg::S_SWEEP;
                rem_next   = count;
                kept_next  = '0;
                mval_next  = value;
              end
            end
            ple_pkg::ACT_OVERWRITE: begin
              if (pos_k >= count_k) begin
                stat_n = ple_pkg::STAT_BADPOS;
              end else begin
                ctl.op = ple_pkg::C_WR;
              end
            end
            ple_pkg::ACT_READ: begin
              if (pos_k >= count_k) begin
                stat_n = ple_pkg::STAT_BADPOS;
              end else begin
                rv_n = rd_or;
              end
            end
            default: begin
              stat_n = ple_pkg::STAT_BADPOS;
            end
          endcase
        end
      end
      ple_pkg::S_SWEEP: begin
        // unprocessed entries sit at [0, rem), kept ones follow them
        ctl.op    = ple_pkg::C_ROT;
        ctl.pos   = KW'(CW'(rem - CW'(1) + kept));
        ctl.data  = cell_val[0];
        ctl.wen   = keep;
        rem_next  = rem - CW'(1);
        kept_next = kept + CW'(keep);
        if (rem == CW'(1)) begin
          count_next = kept_next;
          load       = 1'b1;
          state_next = ple_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ple_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ple_pkg::S_IDLE;
      count     <= '0;
      rem       <= '0;
      kept      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rem   <= rem_next;
      kept  <= kept_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mval <= mval_next;
    if (load) begin
      status     <= stat_n;
      read_value <= rv_n;
      length     <= ple_pkg::PW'(count_next);
    end
  end

endmodule

// ===== hdl/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell
// One list entry; takes its left or right neighbor on a shift, or new data.
// ----------------------------------------------------------------------------
module ple_cell (
  input  logic                          clk,
  input  ple_pkg::cell_ctl_t            ctl,
  input  logic [ple_pkg::KW-1:0]        idx,
  input  logic [ple_pkg::DW-1:0]        left,
  input  logic [ple_pkg::DW-1:0]        right,
  output logic [ple_pkg::DW-1:0]        val,
  output logic [ple_pkg::DW-1:0]        rd
);

  logic hit;

  assign hit = (idx == ctl.pos);
  assign rd  = hit ? val : '0;

  always_ff @(posedge clk) begin
    case (ctl.op)
      ple_pkg::C_INS: begin
        if (hit) begin
          val <= ctl.data;
        end else if (idx > ctl.pos) begin
          val <= left;
        end
      end
      ple_pkg::C_DEL: begin
        if (idx >= ctl.pos) begin
          val <= right;
        end
      end
      ple_pkg::C_WR: begin
        if (hit) begin
          val <= ctl.data;
        end
      end
      ple_pkg::C_ROT: begin
        // whole chain moves down one; a kept head lands at the tail of the kept run
        if (ctl.wen && hit) begin
          val <= ctl.data;
        end else begin
          val <= right;
        end
      end
      default: begin
        val <= val;
      end
    endcase
  end

endmodule
